>>> hdl/grd_pkg.sv
// ----------------------------------------------------------------------------
// grd_pkg
// shared widths, codes and result types of the grid run-length decoder
// ----------------------------------------------------------------------------
package grd_pkg;

    localparam int MAX_CELLS  = 65536;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 20;
    localparam int CELL_W     = 17;
    localparam int VAL_W      = 16;
    localparam int STAT_W     = 3;
    localparam int DECL_W     = 32;
    localparam int PART_W     = 24;
    localparam int MODE_W     = 8;

    // header layout
    localparam int HDR_LEN      = 5;
    localparam int HDR_MODE_POS = 4;

    // results one byte can cause: payload run, zero fill, status
    localparam int RES_SLOTS  = 3;
    localparam int SLOT_RUN   = 0;
    localparam int SLOT_FILL  = 1;
    localparam int SLOT_STAT  = 2;

    localparam int FIFO_DEPTH = 8;

    localparam logic [CELL_W-1:0] CAP_RESET = CELL_W'(65536);

    localparam logic [MODE_W-1:0] MODE_RLE = 8'd0;
    localparam logic [MODE_W-1:0] MODE_RAW = 8'd1;

    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_OVER_CAP  = 3'd2,
        ST_BAD_MODE  = 3'd3,
        ST_RAW_SHORT = 3'd4
    } t_status;

    typedef struct packed {
        logic                kind;
        logic [CELL_W-1:0]   start;
        logic [CELL_W-1:0]   len;
        logic [VAL_W-1:0]    value;
        t_status             status;
        logic                last;
    } t_result;

    typedef struct packed {
        logic    [RES_SLOTS-1:0] vld;
        t_result [RES_SLOTS-1:0] res;
    } t_push;

endpackage

>>> hdl/grd_decode.sv
// ----------------------------------------------------------------------------
// grd_decode
// input register, header and payload parsing, run generation
// ----------------------------------------------------------------------------
module grd_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [grd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [grd_pkg::LEN_W-1:0]  i_buffer_length,
    input  logic                       i_last_byte,
    input  logic                       i_cfg_we,
    input  logic [grd_pkg::CELL_W-1:0] i_cfg_data,
    output grd_pkg::t_push             o_push
);
    import grd_pkg::*;

    localparam logic [LEN_W-1:0]  POS_MAX      = {LEN_W{1'b1}};
    localparam logic [24:0]       MAX_CELLS_EX = 25'(MAX_CELLS);

    // input register
    logic                 r_in_vld;
    logic [BYTE_W-1:0]    r_byte;
    logic [LEN_W-1:0]     r_blen;
    logic                 r_lastb;

    logic [CELL_W-1:0]    r_cap;

    // buffer state
    logic [LEN_W-1:0]     r_pos,      n_pos;
    logic [DECL_W-1:0]    r_declared, n_declared;
    logic [MODE_W-1:0]    r_mode,     n_mode;
    logic [PART_W-1:0]    r_partial,  n_partial;
    logic [CELL_W-1:0]    r_written,  n_written;
    logic                 r_stopped,  n_stopped;
    t_status              r_err,      n_err;

    logic [CELL_W-1:0]    w_cap;
    logic [DECL_W+1:0]    w_raw_need;
    t_status              w_hdr_err;
    t_status              w_stat;
    logic [1:0]           w_idx_lo;
    logic [CELL_W-1:0]    w_room;
    logic [CELL_W-1:0]    w_cnt;
    logic [CELL_W-1:0]    w_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_cap    <= CAP_RESET;
        end else begin
            r_in_vld <= i_accept;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
        if (i_accept) begin
            r_byte  <= i_data_byte;
            r_blen  <= i_buffer_length;
            r_lastb <= i_last_byte;
        end
    end

    always_comb begin
        w_cap = ({8'b0, r_cap} > MAX_CELLS_EX) ? MAX_CELLS_EX[CELL_W-1:0] : r_cap;

        // header checks in priority order
        w_raw_need = {1'b0, r_declared, 1'b0} + (DECL_W+2)'(HDR_LEN);
        if (r_blen < LEN_W'(HDR_LEN)) begin
            w_hdr_err = ST_TOO_SHORT;
        end else if (r_declared > {{(DECL_W-CELL_W){1'b0}}, w_cap}) begin
            w_hdr_err = ST_OVER_CAP;
        end else if (r_byte > MODE_RAW) begin
            w_hdr_err = ST_BAD_MODE;
        end else if (r_byte == MODE_RAW &&
                     w_raw_need > {{(DECL_W+2-LEN_W){1'b0}}, r_blen}) begin
            w_hdr_err = ST_RAW_SHORT;
        end else begin
            w_hdr_err = ST_OK;
        end

        // payload index is position minus header length
        w_idx_lo = r_pos[1:0] + 2'd3;
        w_room   = r_declared[CELL_W-1:0] - r_written;
        w_cnt    = {1'b0, r_partial[PART_W-1:BYTE_W]};
        w_len    = (w_cnt < w_room) ? w_cnt : w_room;

        n_pos      = r_pos;
        n_declared = r_declared;
        n_mode     = r_mode;
        n_partial  = r_partial;
        n_written  = r_written;
        n_stopped  = r_stopped;
        n_err      = r_err;
        o_push     = '0;

        if (r_pos < LEN_W'(HDR_MODE_POS)) begin
            n_declared = {r_declared[DECL_W-BYTE_W-1:0], r_byte};
        end else if (r_pos == LEN_W'(HDR_MODE_POS)) begin
            n_mode = r_byte;
            n_err  = w_hdr_err;
            if (w_hdr_err != ST_OK || r_declared == '0) begin
                n_stopped = 1'b1;
            end
        end else if (!r_stopped && r_pos < r_blen) begin
            if (r_mode == MODE_RAW) begin
                if (!w_idx_lo[0]) begin
                    n_partial = {16'b0, r_byte};
                end else begin
                    n_partial = '0;
                    o_push.vld[SLOT_RUN]       = 1'b1;
                    o_push.res[SLOT_RUN].start = r_written;
                    o_push.res[SLOT_RUN].len   = CELL_W'(1);
                    o_push.res[SLOT_RUN].value = {r_partial[BYTE_W-1:0], r_byte};
                    n_written = r_written + CELL_W'(1);
                end
            end else begin
                if (w_idx_lo != 2'd3) begin
                    n_partial = {r_partial[PART_W-BYTE_W-1:0], r_byte};
                end else begin
                    n_partial = '0;
                    if (w_cnt == '0) begin
                        n_stopped = 1'b1;
                    end else begin
                        o_push.vld[SLOT_RUN]       = 1'b1;
                        o_push.res[SLOT_RUN].start = r_written;
                        o_push.res[SLOT_RUN].len   = w_len;
                        o_push.res[SLOT_RUN].value = {r_partial[BYTE_W-1:0], r_byte};
                        n_written = r_written + w_len;
                    end
                end
            end
            if ({{(DECL_W-CELL_W){1'b0}}, n_written} >= r_declared) begin
                n_stopped = 1'b1;
            end
        end

        if (r_pos != POS_MAX) begin
            n_pos = r_pos + LEN_W'(1);
        end

        w_stat = (r_pos < LEN_W'(HDR_MODE_POS)) ? ST_TOO_SHORT : n_err;
        if (r_lastb) begin
            if (w_stat == ST_OK && n_written < w_cap) begin
                o_push.vld[SLOT_FILL]       = 1'b1;
                o_push.res[SLOT_FILL].start = n_written;
                o_push.res[SLOT_FILL].len   = w_cap - n_written;
            end
            o_push.vld[SLOT_STAT]        = 1'b1;
            o_push.res[SLOT_STAT].kind   = KIND_STATUS;
            o_push.res[SLOT_STAT].status = w_stat;
            o_push.res[SLOT_STAT].last   = 1'b1;
            n_pos      = '0;
            n_declared = '0;
            n_mode     = '0;
            n_partial  = '0;
            n_written  = '0;
            n_stopped  = 1'b0;
            n_err      = ST_OK;
        end

        if (!r_in_vld) begin
            o_push.vld = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_declared <= '0;
            r_mode     <= '0;
            r_partial  <= '0;
            r_written  <= '0;
            r_stopped  <= 1'b0;
            r_err      <= ST_OK;
        end else if (r_in_vld) begin
            r_pos      <= n_pos;
            r_declared <= n_declared;
            r_mode     <= n_mode;
            r_partial  <= n_partial;
            r_written  <= n_written;
            r_stopped  <= n_stopped;
            r_err      <= n_err;
        end
    end

endmodule

>>> hdl/grd_fifo.sv
// ----------------------------------------------------------------------------
// grd_fifo
// result queue, up to three pushes and one pop per cycle
// ----------------------------------------------------------------------------
module grd_fifo #(
    parameter int DEPTH = grd_pkg::FIFO_DEPTH  // power of two, at least 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  grd_pkg::t_push   i_push,
    input  logic             i_pop,
    output grd_pkg::t_result o_head,
    output logic             o_valid,
    output logic             o_room
);
    import grd_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2 * RES_SLOTS);

    t_result           r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr_ptr;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    logic [ADDR_W-1:0] w_off [RES_SLOTS];
    logic [CNT_W-1:0]  w_npush;
    logic              w_pop;

    always_comb begin
        w_off[0] = '0;
        w_npush  = CNT_W'(i_push.vld[0]);
        for (int k = 1; k < RES_SLOTS; k++) begin
            w_off[k] = w_off[k-1] + ADDR_W'(i_push.vld[k-1]);
            w_npush  = w_npush + CNT_W'(i_push.vld[k]);
        end
        w_pop   = i_pop && (r_count != '0);
        n_count = r_count + w_npush - CNT_W'(w_pop);
    end

    // packed writes in slot order so beats leave in result order
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_SLOTS; k++) begin
            if (i_push.vld[k]) begin
                r_mem[r_wr_ptr + w_off[k]] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + ADDR_W'(w_npush);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + ADDR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= ROOM_MAX);

endmodule

>>> hdl/grid_rle_decoder.sv
// ----------------------------------------------------------------------------
// grid_rle_decoder
// path: a taken byte passes the input register, then the result queue, before its first beat
// throughput: one byte per cycle while ready; up to three beats per last byte, one per cycle
// the result queue sets the rate: ready drops while it holds more than depth minus six beats
// reset: synchronous active low, clears buffer state and queue, capacity returns to 65536
// ----------------------------------------------------------------------------
module grid_rle_decoder #(
    parameter int FIFO_DEPTH = grd_pkg::FIFO_DEPTH  // result queue depth, power of two >= 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [grd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [grd_pkg::LEN_W-1:0]  i_buffer_length,
    input  logic                       i_last_byte,
    // capacity register
    input  logic                       i_cfg_we,
    input  logic [grd_pkg::CELL_W-1:0] i_cfg_data,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_result_kind,
    output logic [grd_pkg::CELL_W-1:0] o_start_cell,
    output logic [grd_pkg::CELL_W-1:0] o_run_length,
    output logic [grd_pkg::VAL_W-1:0]  o_cell_value,
    output logic [grd_pkg::STAT_W-1:0] o_status,
    output logic                       o_last
);
    import grd_pkg::*;

    t_push   w_push;
    t_result w_head;
    logic    w_room;
    logic    w_accept;

    // the queue keeps room for the byte in flight and the one being taken
    assign o_ready  = w_room;
    assign w_accept = i_valid && w_room;

    // parser: input register, header checks, payload runs, fill and status
    grd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_data_byte     (i_data_byte),
        .i_buffer_length (i_buffer_length),
        .i_last_byte     (i_last_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_push          (w_push)
    );

    // result queue, doubles as the output register
    grd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_ready),
        .o_head  (w_head),
        .o_valid (o_valid),
        .o_room  (w_room)
    );

    // head of queue drives the result beat
    assign o_result_kind = w_head.kind;
    assign o_start_cell  = w_head.start;
    assign o_run_length  = w_head.len;
    assign o_cell_value  = w_head.value;
    assign o_status      = w_head.status;
    assign o_last        = w_head.last;

endmodule

>>> hdl/grd_checker.sv
// ----------------------------------------------------------------------------
// grd_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
module grd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_result_kind,
    input logic [grd_pkg::CELL_W-1:0] o_start_cell,
    input logic [grd_pkg::CELL_W-1:0] o_run_length,
    input logic [grd_pkg::VAL_W-1:0]  o_cell_value,
    input logic [grd_pkg::STAT_W-1:0] o_status,
    input logic                       o_last
);
    import grd_pkg::*;

    // a stalled beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // a status beat closes the buffer and carries no run
    a_status_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_STATUS |->
            o_last && o_start_cell == '0 && o_run_length == '0 && o_cell_value == '0)
        else $error("malformed status beat");

    // a run beat writes at least one cell and carries no status
    a_run_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == KIND_RUN |->
            !o_last && o_status == '0 && o_run_length != '0)
        else $error("malformed run beat");

    // queue empties on reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

bind grid_rle_decoder grd_checker u_grd_checker (.*);
